FILE: rtl/core/ttrm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ttrm_pkg: shared constants of the task timing running mean monitor
// sizes of the task table, time words, counters and the register map
// ---------------------------------------------------------------------------
package ttrm_pkg;

  // table and arithmetic sizes
  localparam int NUM_TASKS  = 8;
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 16;

  // beat field widths
  localparam int TASK_ID_W = 3;
  localparam int STAMP_W   = 32;
  localparam int OUT_W     = 32;

  localparam int TASK_IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  // mean * count + sample, and the divisor count + 1
  localparam int ACC_W = TIME_BITS + COUNT_BITS;
  localparam int DIV_W = COUNT_BITS + 1;

  // step counter of the shift-add and the bit-serial divide
  localparam int MAX_STEPS = (TIME_BITS > COUNT_BITS) ? TIME_BITS : COUNT_BITS;
  localparam int STEP_W    = $clog2(MAX_STEPS);

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_MONITOR_ENABLE = 1'b0;

endpackage
`default_nettype wire

FILE: rtl/core/ttrm_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ttrm_in_if: task log channel
// valid/ready channel carrying one task run per beat
// ---------------------------------------------------------------------------
interface ttrm_in_if;
  import ttrm_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [TASK_ID_W-1:0] task_id;
  logic [STAMP_W-1:0]   start_stamp;
  logic [STAMP_W-1:0]   end_stamp;

  modport source (output valid, output task_id, output start_stamp, output end_stamp,
                  input ready);
  modport sink (input valid, input task_id, input start_stamp, input end_stamp,
                output ready);
endinterface
`default_nettype wire

FILE: rtl/core/ttrm_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ttrm_out_if: task statistics channel
// valid/ready channel carrying the means of one task per beat
// ---------------------------------------------------------------------------
interface ttrm_out_if;
  import ttrm_pkg::*;

  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] mean_period;
  logic [OUT_W-1:0] mean_exec;
  logic             averages_updated;

  modport source (output valid, output mean_period, output mean_exec,
                  output averages_updated, input ready);
  modport sink (input valid, input mean_period, input mean_exec,
                input averages_updated, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/task_timing_running_mean.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// task_timing_running_mean: per-task timing monitor
// keeps last start, mean period, mean execution time and update count per task
// ---------------------------------------------------------------------------
//  channel   dir   handshake        beat contents
//  in_i      in    valid / ready    task_id, start_stamp, end_stamp
//  out_o     out   valid / ready    mean_period, mean_exec, averages_updated
//  apb       in    psel / penable   monitor_enable at word 0
//
//  a beat that updates the means runs the 16-step shift-add multiply and then
//  the 32-step bit-serial divide in both mean units; any other beat skips
//  them and goes straight to the write-back
//  reset clears every table entry at once, no sweep is needed
//  a new beat is taken while the previous result still waits on out_o; the
//  table write-back waits until the output register is free
// ---------------------------------------------------------------------------
module task_timing_running_mean (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ttrm_in_if.sink                         in_i,
  ttrm_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ttrm_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [ttrm_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [ttrm_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready
);
  import ttrm_pkg::*;

  typedef enum logic [3:0] {
    T_IDLE  = 4'b0001,
    T_PREP  = 4'b0010,
    T_CALC  = 4'b0100,
    T_WRITE = 4'b1000
  } top_state_e;

  top_state_e              state_q, state_d;

  // captured beat
  logic [TASK_ID_W-1:0]    id_q;
  logic [TIME_BITS-1:0]    start_q;
  logic [TIME_BITS-1:0]    stop_q;
  logic                    upd_q, upd_d;

  // per-task table
  logic [TIME_BITS-1:0]    last_start_q  [NUM_TASKS];
  logic [TIME_BITS-1:0]    period_mean_q [NUM_TASKS];
  logic [TIME_BITS-1:0]    exec_mean_q   [NUM_TASKS];
  logic [COUNT_BITS-1:0]   count_q       [NUM_TASKS];

  logic                    monitor_enable_q;

  // output register
  logic                    out_valid_q;
  logic [OUT_W-1:0]        out_period_q;
  logic [OUT_W-1:0]        out_exec_q;
  logic                    out_upd_q;

  logic [TASK_IDX_W-1:0]   idx;
  logic                    in_range;
  logic [TIME_BITS-1:0]    cur_last;
  logic                    first_call;
  logic [TIME_BITS-1:0]    period;
  logic [TIME_BITS-1:0]    exec_time;
  logic                    go;
  logic                    unit_start;
  logic                    period_done, exec_done;
  logic [TIME_BITS-1:0]    period_new, exec_new;
  logic                    in_fire;
  logic                    wr_fire;
  logic                    cfg_wr;
  logic [TIME_BITS-1:0]    res_period, res_exec;

  // ---------------------------------------------------------------------------
  // configuration port, writes are registered in the access phase
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      monitor_enable_q <= 1'b0;
    end else if (cfg_wr && (paddr[CFG_ADDR_W-1:2] == REG_MONITOR_ENABLE)) begin
      monitor_enable_q <= pwdata[0];
    end
  end

  assign prdata = (paddr[CFG_ADDR_W-1:2] == REG_MONITOR_ENABLE)
                ? CFG_DATA_W'(monitor_enable_q) : '0;

  // ---------------------------------------------------------------------------
  // table lookup for the captured task
  // ---------------------------------------------------------------------------
  assign idx        = TASK_IDX_W'(id_q);
  assign in_range   = (int'(id_q) < NUM_TASKS);
  assign cur_last   = last_start_q[idx];
  // a stored start of zero means the task has not run yet
  assign first_call = (cur_last == '0);
  // both differences wrap with the timer
  assign period     = start_q - cur_last;
  assign exec_time  = stop_q - start_q;
  assign go         = in_range && !first_call && monitor_enable_q;
  assign unit_start = (state_q == T_PREP) && go;

  // ---------------------------------------------------------------------------
  // two bit-serial mean units run side by side on the same count
  // ---------------------------------------------------------------------------
  ttrm_mean_unit u_period (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .mean_i  (period_mean_q[idx]),
    .sample_i(period),
    .count_i (count_q[idx]),
    .done_o  (period_done),
    .mean_o  (period_new)
  );

  ttrm_mean_unit u_exec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (unit_start),
    .mean_i  (exec_mean_q[idx]),
    .sample_i(exec_time),
    .count_i (count_q[idx]),
    .done_o  (exec_done),
    .mean_o  (exec_new)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------------
  assign in_i.ready = (state_q == T_IDLE);
  assign in_fire    = in_i.valid && (state_q == T_IDLE);
  // write-back and result load once the output register is free
  assign wr_fire    = (state_q == T_WRITE) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d = state_q;
    upd_d   = upd_q;
    case (state_q)
      T_IDLE: begin
        if (in_i.valid) begin
          state_d = T_PREP;
        end
      end
      T_PREP: begin
        upd_d   = go;
        state_d = go ? T_CALC : T_WRITE;
      end
      T_CALC: begin
        if (period_done && exec_done) begin
          state_d = T_WRITE;
        end
      end
      T_WRITE: begin
        if (wr_fire) begin
          state_d = T_IDLE;
        end
      end
      default: begin
        state_d = T_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      upd_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      upd_q   <= upd_d;
    end
  end

  // beat capture, stamps taken modulo the time word
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      id_q    <= in_i.task_id;
      start_q <= TIME_BITS'(in_i.start_stamp);
      stop_q  <= TIME_BITS'(in_i.end_stamp);
    end
  end

  // ---------------------------------------------------------------------------
  // table write-back, cleared by reset
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        last_start_q[i]  <= '0;
        period_mean_q[i] <= '0;
        exec_mean_q[i]   <= '0;
        count_q[i]       <= '0;
      end
    end else if (wr_fire && in_range) begin
      last_start_q[idx] <= start_q;
      if (upd_q) begin
        period_mean_q[idx] <= period_new;
        exec_mean_q[idx]   <= exec_new;
        // count saturates, the divisor then stays at its top value
        if (count_q[idx] != '1) begin
          count_q[idx] <= count_q[idx] + COUNT_BITS'(1);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------------------
  assign res_period = !in_range ? '0 : (upd_q ? period_new : period_mean_q[idx]);
  assign res_exec   = !in_range ? '0 : (upd_q ? exec_new : exec_mean_q[idx]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_fire) begin
      out_period_q <= OUT_W'(res_period);
      out_exec_q   <= OUT_W'(res_exec);
      out_upd_q    <= upd_q && in_range;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.mean_period      = out_period_q;
  assign out_o.mean_exec        = out_exec_q;
  assign out_o.averages_updated = out_upd_q;

endmodule
`default_nettype wire

FILE: rtl/core/ttrm_mean_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// ttrm_mean_unit: bit-serial running mean
// (mean*n + sample)/(n+1) by shift-add over n, then restoring divide
// ---------------------------------------------------------------------------
module ttrm_mean_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [ttrm_pkg::TIME_BITS-1:0]  mean_i,
  input  logic [ttrm_pkg::TIME_BITS-1:0]  sample_i,
  input  logic [ttrm_pkg::COUNT_BITS-1:0] count_i,
  output logic                            done_o,
  output logic [ttrm_pkg::TIME_BITS-1:0]  mean_o
);
  import ttrm_pkg::*;

  typedef enum logic [3:0] {
    U_IDLE = 4'b0001,
    U_MUL  = 4'b0010,
    U_DIV  = 4'b0100,
    U_DONE = 4'b1000
  } unit_state_e;

  unit_state_e             state_q, state_d;
  logic [STEP_W-1:0]       step_q, step_d;
  logic [ACC_W-1:0]        acc_q, acc_d;
  logic [ACC_W-1:0]        mcand_q, mcand_d;
  logic [COUNT_BITS-1:0]   nsh_q, nsh_d;
  logic [DIV_W-1:0]        div_q, div_d;
  logic [DIV_W-1:0]        rem_q, rem_d;
  logic [DIV_W:0]          trial;
  logic                    ge;

  // remainder stays below the divisor, so trial is below twice the divisor
  assign trial = {rem_q, acc_q[TIME_BITS-1]};
  assign ge    = (trial >= {1'b0, div_q});

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    acc_d   = acc_q;
    mcand_d = mcand_q;
    nsh_d   = nsh_q;
    div_d   = div_q;
    rem_d   = rem_q;
    case (state_q)
      U_IDLE, U_DONE: begin
        if (start_i) begin
          acc_d   = ACC_W'(sample_i);
          mcand_d = ACC_W'(mean_i);
          nsh_d   = count_i;
          div_d   = DIV_W'(count_i) + DIV_W'(1);
          step_d  = STEP_W'(COUNT_BITS - 1);
          state_d = U_MUL;
        end
      end
      U_MUL: begin
        if (nsh_q[0]) begin
          acc_d = acc_q + mcand_q;
        end
        mcand_d = mcand_q << 1;
        nsh_d   = nsh_q >> 1;
        if (step_q == '0) begin
          // quotient fits in a time word, so the high part is below the divisor
          rem_d   = DIV_W'(acc_d[ACC_W-1:TIME_BITS]);
          step_d  = STEP_W'(TIME_BITS - 1);
          state_d = U_DIV;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      U_DIV: begin
        rem_d = ge ? DIV_W'(trial - {1'b0, div_q}) : DIV_W'(trial);
        acc_d[TIME_BITS-1:0] = {acc_q[TIME_BITS-2:0], ge};
        if (step_q == '0) begin
          state_d = U_DONE;
        end else begin
          step_d = step_q - STEP_W'(1);
        end
      end
      default: begin
        state_d = U_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      step_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    nsh_q   <= nsh_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
  end

  assign done_o = (state_q == U_DONE);
  assign mean_o = acc_q[TIME_BITS-1:0];

endmodule
`default_nettype wire

FILE: bench/task_timing_running_mean_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// task_timing_running_mean_test: bench for the per-task timing monitor
// drives task-run beats and apb writes of monitor_enable, keeps its own
// copy of the per-task tables and checks every stats beat in order
// ---------------------------------------------------------------------------
module task_timing_running_mean_test;
  import ttrm_pkg::*;

  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 1000000;
  // settle window, with margin over a full mean update
  localparam int SETTLE_CYCLES = 2 * (COUNT_BITS + TIME_BITS + 4);
  localparam int PHASE_ITEMS   = 440;
  localparam int IDLE_PCT      = 11;
  localparam int MAX_GAP       = 70;
  // no idling on either side inside this window
  localparam int BUSY_FROM = 700;
  localparam int BUSY_TO   = 1000;
  // long receiver hold-off to back the block up into its input
  localparam int HOLD_AT     = 300;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [OUT_W-1:0] mean_period;
    logic [OUT_W-1:0] mean_exec;
    logic             updated;
  } task_stats_t;

  // per-task timing tables mirrored in software, plus the pending stats
  class task_stats_book;
    task_stats_t          pending_stats[$];
    logic [TIME_BITS-1:0] last_start [NUM_TASKS];
    logic [TIME_BITS-1:0] period_avg [NUM_TASKS];
    logic [TIME_BITS-1:0] exec_avg   [NUM_TASKS];
    logic [COUNT_BITS-1:0] run_count [NUM_TASKS];
    logic                 enable;
    int                   mismatches;

    function new();
      for (int i = 0; i < NUM_TASKS; i++) begin
        last_start[i] = '0;
        period_avg[i] = '0;
        exec_avg[i]   = '0;
        run_count[i]  = '0;
      end
      enable     = 1'b0;
      mismatches = 0;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    // truncated cumulative average (mean*n + sample)/(n+1)
    function logic [TIME_BITS-1:0] fold_in(logic [TIME_BITS-1:0] mean,
                                           logic [TIME_BITS-1:0] sample,
                                           logic [COUNT_BITS-1:0] n);
      logic [63:0] acc;
      acc = 64'(mean) * 64'(n) + 64'(sample);
      return TIME_BITS'(acc / (64'(n) + 64'd1));
    endfunction

    function void log_run(logic [TASK_ID_W-1:0] id, logic [STAMP_W-1:0] start,
                          logic [STAMP_W-1:0] stop);
      task_stats_t          s;
      logic [TIME_BITS-1:0] period;
      logic [TIME_BITS-1:0] exec_t;
      logic                 first;
      int                   idx;
      s   = '0;
      idx = int'(id);
      if (idx < NUM_TASKS) begin
        // stored start of zero means no previous run
        first  = (last_start[idx] == '0);
        period = TIME_BITS'(start) - last_start[idx];
        last_start[idx] = TIME_BITS'(start);
        if (!first && enable) begin
          exec_t = TIME_BITS'(stop) - TIME_BITS'(start);
          period_avg[idx] = fold_in(period_avg[idx], period, run_count[idx]);
          exec_avg[idx]   = fold_in(exec_avg[idx], exec_t, run_count[idx]);
          if (run_count[idx] != '1) run_count[idx] = run_count[idx] + 1'b1;
          s.updated = 1'b1;
        end
        s.mean_period = OUT_W'(period_avg[idx]);
        s.mean_exec   = OUT_W'(exec_avg[idx]);
      end
      pending_stats.push_back(s);
    endfunction

    task check_stats(logic [OUT_W-1:0] mp, logic [OUT_W-1:0] me, logic upd);
      task_stats_t want;
      if (pending_stats.size() == 0) begin
        report($sformatf("stats beat with nothing pending: period %0d exec %0d upd %0b",
                         mp, me, upd));
        return;
      end
      want = pending_stats.pop_front();
      if (mp !== want.mean_period)
        report($sformatf("mean_period %0d, want %0d", mp, want.mean_period));
      if (me !== want.mean_exec)
        report($sformatf("mean_exec %0d, want %0d", me, want.mean_exec));
      if (upd !== want.updated)
        report($sformatf("averages_updated %0b, want %0b", upd, want.updated));
    endtask
  endclass

  logic clk_i;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  ttrm_in_if  run_if ();
  ttrm_out_if stats_if ();

  task_stats_book book;

  int   cycle_count  = 0;
  int   beats_sent   = 0;
  int   stats_seen   = 0;
  logic hold_off     = 1'b0;

  // software clock per task for well-formed run sequences
  logic [STAMP_W-1:0] task_clock [NUM_TASKS];

  task_timing_running_mean i_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (run_if),
    .out_o   (stats_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // run beats, predicted the moment they are taken
  always @(posedge clk_i) begin
    if (rst_ni && run_if.valid && run_if.ready)
      book.log_run(run_if.task_id, run_if.start_stamp, run_if.end_stamp);
  end

  // stats beats are checked against the oldest prediction, then ready is redrawn
  always @(posedge clk_i) begin
    if (rst_ni && stats_if.valid && stats_if.ready) begin
      book.check_stats(stats_if.mean_period, stats_if.mean_exec, stats_if.averages_updated);
      stats_seen++;
    end
    if (hold_off)
      stats_if.ready <= 1'b0;
    else if (stats_seen >= BUSY_FROM && stats_seen < BUSY_TO)
      stats_if.ready <= 1'b1;
    else
      stats_if.ready <= ($urandom_range(99) >= IDLE_PCT);
  end

  // long back-pressure window, counted here in cycles
  initial begin
    wait (stats_seen >= HOLD_AT);
    @(posedge clk_i);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off <= 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // one run beat; returns at the edge where it was taken
  task automatic push_run(logic [TASK_ID_W-1:0] id, logic [STAMP_W-1:0] start,
                          logic [STAMP_W-1:0] stop);
    int gap;
    gap = 0;
    if (!(beats_sent >= BUSY_FROM && beats_sent < BUSY_TO) &&
        $urandom_range(99) < IDLE_PCT)
      gap = $urandom_range(1, MAX_GAP);
    if (gap > 0) begin
      run_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    run_if.valid       <= 1'b1;
    run_if.task_id     <= id;
    run_if.start_stamp <= start;
    run_if.end_stamp   <= stop;
    @(posedge clk_i);
    while (!run_if.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic push_random_run();
    int                 id;
    int                 kind;
    logic [STAMP_W-1:0] st;
    logic [STAMP_W-1:0] en;
    id   = $urandom_range(NUM_TASKS - 1);
    kind = $urandom_range(99);
    if (kind < 80) begin
      // plausible timer sequence: mostly short periods and runs, some huge jumps
      st = task_clock[id] + (($urandom_range(9) == 0) ? $urandom : $urandom_range(1, 5000));
      en = st + (($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 2000));
      task_clock[id] = st;
    end else if (kind < 90) begin
      st = $urandom;
      en = $urandom;
    end else if (kind < 95) begin
      // zero start, next run of this task counts as a first call
      st = '0;
      en = $urandom;
    end else begin
      st = '1;
      en = $urandom_range(1) ? '1 : '0;
    end
    push_run(TASK_ID_W'(id), st, en);
  endtask

  task automatic cfg_write(logic [CFG_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * REG_MONITOR_ENABLE);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    book.enable = data[0];
  endtask

  task automatic cfg_check_enable();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= CFG_ADDR_W'(4 * REG_MONITOR_ENABLE);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata[0] !== book.enable)
      book.report($sformatf("monitor_enable reads %0b, want %0b", prdata[0], book.enable));
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // block idle: every stats beat back, then let the pipeline settle
  task automatic drain();
    // one edge first so the last accepted beat is already predicted
    @(posedge clk_i);
    while (book.pending_stats.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_directed();
    // monitor off after reset: only start times get recorded
    push_run(3'd0, 32'd1000, 32'd1200);
    push_run(3'd0, 32'd2000, 32'd2100);
    run_if.valid <= 1'b0;
    drain();
    cfg_write(32'h0000_0001);
    cfg_check_enable();
    // first real updates, then a zero start and the first call that follows
    push_run(3'd0, 32'd3000, 32'd3050);
    push_run(3'd0, 32'd4500, 32'd4600);
    push_run(3'd0, 32'd0,    32'd0);
    push_run(3'd0, 32'd100,  32'd200);
    push_run(3'd0, 32'd350,  32'd351);
    // timer wrap on exec and then on period
    push_run(3'd1, 32'hFFFF_FFF0, 32'h0000_0010);
    push_run(3'd1, 32'h0000_0020, 32'h0000_001F);
    // stamp extremes
    push_run(3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_run(3'd2, 32'h7FFF_FFFF, 32'h0000_0000);
    push_run(3'd2, 32'hFFFF_FFFF, 32'h0000_0000);
    push_run(3'd7, 32'h0000_0001, 32'hFFFF_FFFF);
    push_run(3'd7, 32'h0000_0002, 32'h0000_0001);
    push_run(3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // huge periods pile up a large mean times count
    for (int k = 1; k <= 8; k++)
      push_run(3'd3, 32'(k) * 32'h1FFF_FFFF + 32'd1, 32'hFFFF_FFFE);
    push_run(3'd6, 32'h8000_0000, 32'h8000_0000);
    run_if.valid <= 1'b0;
  endtask

  initial begin
    logic enable_plan [4];
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    run_if.valid         = 1'b0;
    run_if.task_id       = '0;
    run_if.start_stamp   = '0;
    run_if.end_stamp     = '0;
    stats_if.ready       = 1'b0;
    book                 = new();
    for (int i = 0; i < NUM_TASKS; i++) task_clock[i] = $urandom;
    enable_plan = '{1'b1, 1'b0, 1'b1, 1'b1};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    cfg_check_enable();

    run_directed();

    // random phases, each under its own monitor_enable setting
    foreach (enable_plan[p]) begin
      drain();
      // random upper bits, bit 0 carries the enable
      cfg_write({31'($urandom), enable_plan[p]});
      cfg_check_enable();
      repeat (PHASE_ITEMS) push_random_run();
      run_if.valid <= 1'b0;
    end

    drain();
    if (book.pending_stats.size() != 0)
      book.report($sformatf("%0d stats beats never arrived", book.pending_stats.size()));
    if (book.mismatches == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
